FILE: design/otq_pkg.sv
// Shared types and constants of the ordered timer queue.
package otq_pkg;

  localparam int unsigned TimerSlotsDefault = 16;
  localparam int unsigned MaxResults        = 16;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    K_CREATED   = 3'd0,
    K_FIRED     = 3'd1,
    K_CANCELLED = 3'd2,
    K_CLEARED   = 3'd3,
    K_NOTHING   = 3'd4,
    K_FULL      = 3'd5,
    K_BADHANDLE = 3'd6
  } kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  latch;
    logic  scan_clr;
    logic  scan_step;
    logic  rd_en;
    logic  rd_hnd;
    logic  div_start;
    logic  mem_wr;
    logic  cancel_clr;
    logic  best_clr;
    logic  fire;
    logic  clear_all;
    logic  out_load;
    kind_e out_kind;
    logic  out_last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic free_hit;
    logic scan_last;
    logic jit_nz;
    logic h_ok;
    logic div_done;
    logic best_due;
    logic pend_have;
    logic n_full;
    logic out_free;
  } sts_t;

endpackage

FILE: design/otq_div.sv
// Bit-serial restoring divider giving the remainder of a 32-bit division.
module otq_div import otq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic [31:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] trial;
  logic [32:0] diff;

  // one quotient bit per cycle
  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], 1'b0};
      rem_q <= diff[32] ? trial[31:0] : diff[31:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/otq_dp.sv
// Datapath: slot table, scan for the earliest timer, divider and result register.
module otq_dp import otq_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = TimerSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] duration_ms_i,
  input  logic [31:0] jitter_range_i,
  input  logic [31:0] random_value_i,
  input  logic [31:0] user_context_i,
  input  logic [3:0]  slot_handle_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [2:0]  result_kind_o,
  output logic [3:0]  out_handle_o,
  output logic [31:0] out_context_o,
  output logic [31:0] expires_at_o,
  output logic        last_result_o
);

  localparam int unsigned SW = $clog2(TIMER_SLOTS);
  localparam int unsigned CW = $clog2(MaxResults + 1);
  localparam logic [SW-1:0] LastIdx = SW'(TIMER_SLOTS - 1);

  // latched item
  logic [31:0] now_q, dur_q, jit_q, rnd_q, ctx_q;
  logic [3:0]  hnd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      now_q <= now_ms_i;
      dur_q <= duration_ms_i;
      jit_q <= jitter_range_i;
      rnd_q <= random_value_i;
      ctx_q <= user_context_i;
      hnd_q <= slot_handle_i;
    end
  end

  // handle check
  logic [7:0]    h8;
  logic [SW-1:0] h_idx;
  assign h8    = 8'(hnd_q);
  assign h_idx = h8[SW-1:0];

  // jitter remainder
  logic        div_done;
  logic [31:0] div_rem;
  logic        jit_nz;
  logic [31:0] new_exp;

  assign jit_nz = (jit_q != 32'd0);

  otq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rnd_q),
    .divisor_i  (jit_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign new_exp = now_q + dur_q + (jit_nz ? div_rem : 32'd0);

  // scan counter, also the create slot index
  logic [SW-1:0] scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (cmd_i.scan_clr) begin
      scan_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_q <= scan_q + SW'(1);
    end
  end

  // slot memories, one write and one registered read port
  logic [31:0]   mem_exp [TIMER_SLOTS];
  logic [31:0]   mem_seq [TIMER_SLOTS];
  logic [31:0]   mem_ctx [TIMER_SLOTS];
  logic [SW-1:0] rd_addr;
  logic [31:0]   rd_exp_q, rd_seq_q, rd_ctx_q;
  logic [SW-1:0] rd_idx_q;
  logic [31:0]   seq_q;

  assign rd_addr = cmd_i.rd_hnd ? h_idx : scan_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_exp[scan_q] <= new_exp;
      mem_seq[scan_q] <= seq_q;
      mem_ctx[scan_q] <= ctx_q;
    end
    if (cmd_i.rd_en) begin
      rd_exp_q <= mem_exp[rd_addr];
      rd_seq_q <= mem_seq[rd_addr];
      rd_ctx_q <= mem_ctx[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  // sequence counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (cmd_i.mem_wr) begin
      seq_q <= seq_q + 32'd1;
    end
  end

  // running minimum over the scanned slots
  logic          cmp_q;
  logic          best_hit_q;
  logic [31:0]   best_exp_q, best_seq_q, best_ctx_q;
  logic [SW-1:0] best_idx_q;
  logic [TIMER_SLOTS-1:0] valid_q;
  logic          cand_ok;

  assign cand_ok = cmp_q && valid_q[rd_idx_q] &&
                   (!best_hit_q || (rd_exp_q < best_exp_q) ||
                    ((rd_exp_q == best_exp_q) && (rd_seq_q < best_seq_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q      <= 1'b0;
      best_hit_q <= 1'b0;
    end else begin
      cmp_q <= cmd_i.rd_en && !cmd_i.rd_hnd;
      if (cmd_i.best_clr) begin
        best_hit_q <= 1'b0;
      end else if (cand_ok) begin
        best_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_ok) begin
      best_exp_q <= rd_exp_q;
      best_seq_q <= rd_seq_q;
      best_ctx_q <= rd_ctx_q;
      best_idx_q <= rd_idx_q;
    end
  end

  // fired timer held back until it is known whether it is the last one
  logic [CW-1:0] n_q;
  logic [31:0]   pend_exp_q, pend_ctx_q;
  logic [SW-1:0] pend_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cmd_i.latch) begin
      n_q <= '0;
    end else if (cmd_i.fire) begin
      n_q <= n_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      pend_exp_q <= best_exp_q;
      pend_ctx_q <= best_ctx_q;
      pend_idx_q <= best_idx_q;
    end
  end

  // slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear_all) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.mem_wr) begin
        valid_q[scan_q] <= 1'b1;
      end
      if (cmd_i.cancel_clr) begin
        valid_q[h_idx] <= 1'b0;
      end
      if (cmd_i.fire) begin
        valid_q[best_idx_q] <= 1'b0;
      end
    end
  end

  // result register
  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [3:0]  hout_q;
  logic [31:0] cout_q, eout_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q <= cmd_i.out_kind;
      last_q <= cmd_i.out_last;
      case (cmd_i.out_kind)
        K_CREATED: begin
          hout_q <= 4'(scan_q);
          cout_q <= ctx_q;
          eout_q <= new_exp;
        end
        K_FIRED: begin
          hout_q <= 4'(pend_idx_q);
          cout_q <= pend_ctx_q;
          eout_q <= pend_exp_q;
        end
        K_CANCELLED: begin
          hout_q <= hnd_q;
          cout_q <= rd_ctx_q;
          eout_q <= rd_exp_q;
        end
        K_BADHANDLE: begin
          hout_q <= hnd_q;
          cout_q <= '0;
          eout_q <= '0;
        end
        default: begin
          hout_q <= '0;
          cout_q <= '0;
          eout_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign out_handle_o  = hout_q;
  assign out_context_o = cout_q;
  assign expires_at_o  = eout_q;
  assign last_result_o = last_q;

  // status
  always_comb begin
    sts_o.free_hit  = !valid_q[scan_q];
    sts_o.scan_last = (scan_q == LastIdx);
    sts_o.jit_nz    = jit_nz;
    sts_o.h_ok      = (h8 < 8'(TIMER_SLOTS)) && valid_q[h_idx];
    sts_o.div_done  = div_done;
    sts_o.best_due  = best_hit_q && (best_exp_q <= now_q);
    sts_o.pend_have = (n_q != '0);
    sts_o.n_full    = (n_q == CW'(MaxResults));
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // checks
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

  a_fire_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire |-> (best_hit_q && best_exp_q <= now_q && valid_q[best_idx_q]))
    else $error("fired a timer that is not due");

  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MaxResults))
    else $error("fire count beyond limit");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_wr |=> (seq_q == $past(seq_q) + 32'd1))
    else $error("sequence counter did not advance on create");

endmodule

FILE: design/otq_ctrl.sv
// Controller state machine sequencing create, cancel, tick and clear.
module otq_ctrl import otq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  output logic       in_stall_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_C_FIND = 15'b000000000000010,
    S_C_DIV  = 15'b000000000000100,
    S_C_OUT  = 15'b000000000001000,
    S_C_FULL = 15'b000000000010000,
    S_X_CHK  = 15'b000000000100000,
    S_X_BAD  = 15'b000000001000000,
    S_X_OUT  = 15'b000000010000000,
    S_T_INIT = 15'b000000100000000,
    S_T_SCAN = 15'b000001000000000,
    S_T_SEND = 15'b000010000000000,
    S_T_DEC  = 15'b000100000000000,
    S_T_CHK  = 15'b001000000000000,
    S_T_END  = 15'b010000000000000,
    S_L_OUT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_kind = K_NOTHING;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (opcode_e'(opcode_i))
            OP_CREATE: begin
              cmd_o.scan_clr = 1'b1;
              state_d = S_C_FIND;
            end
            OP_CANCEL: state_d = S_X_CHK;
            OP_TICK:   state_d = S_T_INIT;
            OP_CLEAR:  state_d = S_L_OUT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      // walk the valid bits for the lowest free slot
      S_C_FIND: begin
        if (sts_i.free_hit) begin
          if (sts_i.jit_nz) begin
            cmd_o.div_start = 1'b1;
            state_d = S_C_DIV;
          end else begin
            state_d = S_C_OUT;
          end
        end else if (sts_i.scan_last) begin
          state_d = S_C_FULL;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_C_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_C_OUT;
        end
      end
      S_C_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.mem_wr   = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = K_CREATED;
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_C_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = K_FULL;
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_X_CHK: begin
        if (sts_i.h_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_hnd = 1'b1;
          state_d = S_X_OUT;
        end else begin
          state_d = S_X_BAD;
        end
      end
      S_X_BAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = K_BADHANDLE;
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_X_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.cancel_clr = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = K_CANCELLED;
          cmd_o.out_last   = 1'b1;
          state_d = S_IDLE;
        end
      end
      // one full pass over the table per fired timer
      S_T_INIT: begin
        cmd_o.scan_clr = 1'b1;
        cmd_o.best_clr = 1'b1;
        state_d = S_T_SCAN;
      end
      S_T_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_T_SEND;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_T_SEND: state_d = S_T_DEC;
      S_T_DEC: begin
        if (!sts_i.best_due) begin
          state_d = S_T_END;
        end else if (!sts_i.pend_have || sts_i.out_free) begin
          // previous fired timer goes out, it is not the last
          cmd_o.out_load = sts_i.pend_have;
          cmd_o.out_kind = K_FIRED;
          cmd_o.fire     = 1'b1;
          state_d = S_T_CHK;
        end
      end
      S_T_CHK: begin
        state_d = sts_i.n_full ? S_T_END : S_T_INIT;
      end
      S_T_END: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = sts_i.pend_have ? K_FIRED : K_NOTHING;
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_L_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.clear_all = 1'b1;
          cmd_o.out_load  = 1'b1;
          cmd_o.out_kind  = K_CLEARED;
          cmd_o.out_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("item accepted while busy");

  a_fire_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fire |=> (state_q == S_T_CHK))
    else $error("fire outside tick sequence");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.mem_wr, cmd_o.cancel_clr, cmd_o.fire, cmd_o.clear_all}) <= 1)
    else $error("conflicting table updates");

endmodule

FILE: design/ordered_timer_queue.sv
// Top level of the ordered timer queue.
//
//   channel | direction | handshake               | payload
//   input   | in        | in_valid_i / in_stall_o  | opcode, now, duration, jitter, random,
//           |           |                         | context, handle
//   result  | out       | out_valid_o / out_stall_i | kind, handle, context, expiry, last
//
// One item at a time. Create walks the slots to the first free one, runs the
// bit-serial remainder unit when the jitter range is nonzero, then writes the
// slot and its result. Cancel checks the handle and reads the slot. Clear gives
// one result. Tick makes one table scan per fired timer, then a scan that finds
// nothing due (skipped once 16 have fired), then the final result.
// Reset clears all slots and the sequence counter at once.
// A stalled result holds the sequencer at its next result; a new item is
// taken while the final result still waits in the result register.
module ordered_timer_queue import otq_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = TimerSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] duration_ms_i,
  input  logic [31:0] jitter_range_i,
  input  logic [31:0] random_value_i,
  input  logic [31:0] user_context_i,
  input  logic [3:0]  slot_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [3:0]  out_handle_o,
  output logic [31:0] out_context_o,
  output logic [31:0] expires_at_o,
  output logic        last_result_o
);

  cmd_t cmd;
  sts_t sts;

  otq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  otq_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .now_ms_i       (now_ms_i),
    .duration_ms_i  (duration_ms_i),
    .jitter_range_i (jitter_range_i),
    .random_value_i (random_value_i),
    .user_context_i (user_context_i),
    .slot_handle_i  (slot_handle_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .result_kind_o  (result_kind_o),
    .out_handle_o   (out_handle_o),
    .out_context_o  (out_context_o),
    .expires_at_o   (expires_at_o),
    .last_result_o  (last_result_o)
  );

endmodule
